// ----- rtl/rmst_pkg.sv -----
`timescale 1ns / 1ps
// rmst_pkg: operation codes, register indexes and reset constants of the
// range-minimum segment tree; no dependencies
package rmst_pkg;

    // operation codes of the request word
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_POSITIONS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EMPTY     = 1'b1;

    // reset contents of the configuration registers and of the node store
    localparam int          RESET_POSITIONS   = 1024;
    localparam logic [63:0] RESET_EMPTY_WORD  = 64'd1000000000;

endpackage

// ----- rtl/rmst_if.sv -----
`timescale 1ns / 1ps
// rmst_req_if / rmst_rsp_if: valid/ready channels of the segment tree
// depends on nothing; widths come from the interface parameters
interface rmst_req_if #(
    parameter int POS_BITS   = 11,
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic [POS_BITS-1:0]          start_position;
    logic [POS_BITS-1:0]          end_position;
    logic signed [VALUE_BITS-1:0] write_value;

    modport source (output valid, output operation, output start_position,
                    output end_position, output write_value, input ready);
    modport sink   (input valid, input operation, input start_position,
                    input end_position, input write_value, output ready);
endinterface

interface rmst_rsp_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] minimum;
    logic                         bad_range;

    modport source (output valid, output minimum, output bad_range, input ready);
    modport sink   (input valid, input minimum, input bad_range, output ready);
endinterface

// ----- rtl/range_min_segment_tree.sv -----
`timescale 1ns / 1ps
// range_min_segment_tree: bottom-up segment tree with signed minimum merge
// depends on rmst_pkg, rmst_if, rmst_ram, rmst_min
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+---------------------------------------------
//  req     | in  | req.valid/ready    | operation, start_position, end_position,
//          |     |                    | write_value
//  rsp     | out | rsp.valid/ready    | minimum, bad_range (queries only)
//  cfg     | in  | cfg_we             | cfg_index, cfg_data (no read-back)
//
//  write: leaf write, then one node per level up to the root (each
//    level reads the sibling and writes the parent through the ram's separate ports)
//  query: walks the span bounds up one tree level at a time, folding the nodes
//    they take, stopping once the bounds meet, then hands over the result when rsp
//    is free; an empty or bad span ends the walk at once
//  clear: every node of the store, 2*LEAVES in all, one node written a cycle
//  reset: a clearing pass over all 2*LEAVES nodes (2048 by default) fills the store
//    with the reset empty value; req.ready stays low, cfg writes are taken
//  a finished query waits in the output register; req is taken again while it
//    waits, a later query stalls at its end until rsp is free
module range_min_segment_tree
    import rmst_pkg::*;
#(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic [CFG_IDX_BITS-1:0]                      cfg_index,
    input  logic [((VALUE_BITS > $clog2(LEAVES + 1)) ?
                   VALUE_BITS : $clog2(LEAVES + 1))-1:0] cfg_data,
    rmst_req_if.sink                                     req,
    rmst_rsp_if.source                                   rsp
);
    localparam int POS_BITS  = $clog2(LEAVES + 1);      // position and count width
    localparam int ADDR_BITS = $clog2(2 * LEAVES);      // node store address
    localparam int IDX_BITS  = $clog2(2 * LEAVES + 1);  // span bounds reach 2*LEAVES
    localparam int RESET_POS = (RESET_POSITIONS > LEAVES) ? LEAVES : RESET_POSITIONS;
    localparam logic [VALUE_BITS-1:0] RESET_EMPTY = RESET_EMPTY_WORD[VALUE_BITS-1:0];
    localparam logic [ADDR_BITS-1:0]  LAST_NODE   = ADDR_BITS'(2 * LEAVES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,    // sweep fill value over every node
        S_IDLE,     // waiting for a request word
        S_LEAF,     // write the leaf, fetch its sibling
        S_UP,       // one ancestor per cycle towards the root
        S_QUERY     // walk the span bounds upwards, folding nodes
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_BITS-1:0]    lo_reg, lo_next;         // leaf/node index or span start
    logic [IDX_BITS-1:0]    hi_reg, hi_next;         // span end, exclusive
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;       // climbing value or running minimum
    logic                   rd_pend_reg, rd_pend_next;
    logic                   qbad_reg, qbad_next;
    logic [ADDR_BITS-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [VALUE_BITS-1:0]  fill_reg, fill_next;
    logic [POS_BITS-1:0]    positions_reg, positions_next;
    logic [VALUE_BITS-1:0]  empty_reg, empty_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [VALUE_BITS-1:0]  rsp_min_reg, rsp_min_next;
    logic                   rsp_bad_reg, rsp_bad_next;

    logic                   mem_we;
    logic [ADDR_BITS-1:0]   mem_waddr;
    logic [VALUE_BITS-1:0]  mem_wdata;
    logic [ADDR_BITS-1:0]   mem_raddr;
    logic [VALUE_BITS-1:0]  mem_rdata;
    logic [VALUE_BITS-1:0]  min_y;

    logic [POS_BITS-1:0]    active_n;
    logic                   out_free;
    logic [IDX_BITS-1:0]    parent;
    logic [IDX_BITS-1:0]    hi_dec;
    logic [VALUE_BITS-1:0]  acc_fold;

    // node store, node 1 is the root, leaf p sits at node LEAVES + p
    rmst_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (2 * LEAVES)
    ) u_nodes (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // one comparator: held value against the node just read
    rmst_min #(
        .WIDTH (VALUE_BITS)
    ) u_min (
        .a (acc_reg),
        .b (mem_rdata),
        .y (min_y)
    );

    // address of the other child under the same parent
    function automatic logic [ADDR_BITS-1:0] lo_next_sibling(input logic [IDX_BITS-1:0] node);
        logic [IDX_BITS-1:0] sib;
        sib = node ^ IDX_BITS'(1);
        return sib[ADDR_BITS-1:0];
    endfunction

    // count of usable positions, out of range register values clamped
    always_comb
    begin
        if (positions_reg == '0)
        begin
            active_n = POS_BITS'(1);
        end
        else if (positions_reg > POS_BITS'(LEAVES))
        begin
            active_n = POS_BITS'(LEAVES);
        end
        else
        begin
            active_n = positions_reg;
        end
    end

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign parent    = lo_reg >> 1;
    assign hi_dec    = hi_reg - IDX_BITS'(1);
    assign acc_fold  = rd_pend_reg ? min_y : acc_reg;

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.minimum   = rsp_min_reg;
    assign rsp.bad_range = rsp_bad_reg;

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        acc_next       = acc_reg;
        rd_pend_next   = 1'b0;
        qbad_next      = qbad_reg;
        clr_cnt_next   = clr_cnt_reg;
        fill_next      = fill_reg;
        positions_next = positions_reg;
        empty_next     = empty_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_min_next   = rsp_min_reg;
        rsp_bad_next   = rsp_bad_reg;
        mem_we         = 1'b0;
        mem_waddr      = lo_reg[ADDR_BITS-1:0];
        mem_wdata      = acc_reg;
        mem_raddr      = lo_reg[ADDR_BITS-1:0];

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POSITIONS: positions_next = cfg_data[POS_BITS-1:0];
                REG_EMPTY:     empty_next     = cfg_data[VALUE_BITS-1:0];
                default:       ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = fill_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_BITS'(1);
                if (clr_cnt_reg == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.operation)
                        OP_WRITE:
                        begin
                            // writes beyond the usable positions are dropped
                            if (req.start_position < active_n)
                            begin
                                lo_next    = IDX_BITS'(LEAVES) +
                                             IDX_BITS'(req.start_position);
                                acc_next   = req.write_value;
                                state_next = S_LEAF;
                            end
                        end
                        OP_QUERY:
                        begin
                            acc_next = empty_reg;
                            if ((req.start_position > req.end_position) ||
                                (req.end_position > active_n))
                            begin
                                // bad span: empty walk, flagged result
                                qbad_next = 1'b1;
                                lo_next   = '0;
                                hi_next   = '0;
                            end
                            else
                            begin
                                qbad_next = 1'b0;
                                lo_next   = IDX_BITS'(LEAVES) +
                                            IDX_BITS'(req.start_position);
                                hi_next   = IDX_BITS'(LEAVES) +
                                            IDX_BITS'(req.end_position);
                            end
                            state_next = S_QUERY;
                        end
                        OP_CLEAR:
                        begin
                            fill_next    = empty_reg;
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end

            S_LEAF:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg[ADDR_BITS-1:0];
                mem_wdata  = acc_reg;
                mem_raddr  = lo_next_sibling(lo_reg);
                state_next = S_UP;
            end

            S_UP:
            begin
                // sibling arrived: parent = min(held child, sibling)
                mem_we    = 1'b1;
                mem_waddr = parent[ADDR_BITS-1:0];
                mem_wdata = min_y;
                mem_raddr = lo_next_sibling(parent);
                acc_next  = min_y;
                lo_next   = parent;
                if (parent == IDX_BITS'(1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_QUERY:
            begin
                acc_next = acc_fold;
                if (lo_reg >= hi_reg)
                begin
                    // span exhausted, hand over once the output is free
                    if (out_free)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_min_next   = acc_fold;
                        rsp_bad_next   = qbad_reg;
                        state_next     = S_IDLE;
                    end
                end
                else if (lo_reg[0])
                begin
                    mem_raddr    = lo_reg[ADDR_BITS-1:0];
                    rd_pend_next = 1'b1;
                    if (hi_reg[0])
                    begin
                        // right bound still to take, next cycle
                        lo_next = lo_reg + IDX_BITS'(1);
                    end
                    else
                    begin
                        lo_next = (lo_reg + IDX_BITS'(1)) >> 1;
                        hi_next = hi_reg >> 1;
                    end
                end
                else if (hi_reg[0])
                begin
                    mem_raddr    = hi_dec[ADDR_BITS-1:0];
                    rd_pend_next = 1'b1;
                    lo_next      = lo_reg >> 1;
                    hi_next      = hi_reg >> 1;
                end
                else
                begin
                    lo_next = lo_reg >> 1;
                    hi_next = hi_reg >> 1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            lo_reg        <= '0;
            hi_reg        <= '0;
            acc_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            qbad_reg      <= 1'b0;
            clr_cnt_reg   <= '0;
            fill_reg      <= RESET_EMPTY;
            positions_reg <= POS_BITS'(RESET_POS);
            empty_reg     <= RESET_EMPTY;
            rsp_valid_reg <= 1'b0;
            rsp_min_reg   <= '0;
            rsp_bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            acc_reg       <= acc_next;
            rd_pend_reg   <= rd_pend_next;
            qbad_reg      <= qbad_next;
            clr_cnt_reg   <= clr_cnt_next;
            fill_reg      <= fill_next;
            positions_reg <= positions_next;
            empty_reg     <= empty_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_min_reg   <= rsp_min_next;
            rsp_bad_reg   <= rsp_bad_next;
        end
    end

    // a result only ever comes out of the query walk
    a_rsp_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_QUERY))
        else $error("result raised outside a query");

    // the climb never reaches the root or node zero as its held child
    a_climb_below_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP) |-> (lo_reg >= IDX_BITS'(2)))
        else $error("ancestor climb overran the root");

    // read data is folded only for reads issued by the query walk
    a_fold_after_query_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(state_reg == S_QUERY))
        else $error("pending read outside a query");

    // the store is never written while waiting for a word
    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("node store written while idle");

endmodule

// ----- rtl/rmst_ram.sv -----
`timescale 1ns / 1ps
// rmst_ram: generic single-write, single-read memory with registered read
// no dependencies
module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/rmst_min.sv -----
`timescale 1ns / 1ps
// rmst_min: shared signed minimum unit, used for ancestor updates and
// query folding; no dependencies
module rmst_min #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] y
);
    // ties keep a (identical bits either way)
    assign y = ($signed(a) <= $signed(b)) ? a : b;
endmodule
